### rtl/pbdc_pkg.sv
// Package for the pixel bit depth converter.
// Holds depth codes, register indexes and the scale constants. No dependencies.
package pbdc_pkg;

  typedef enum logic [1:0] {
    DEPTH_BYTE  = 2'd0,
    DEPTH_SHORT = 2'd1,
    DEPTH_FLOAT = 2'd2,
    DEPTH_ALT   = 2'd3
  } depth_t;

  typedef enum logic [1:0] {
    REG_SOURCE_DEPTH = 2'd0,
    REG_TARGET_DEPTH = 2'd1,
    REG_SPARE_A      = 2'd2,
    REG_SPARE_B      = 2'd3
  } reg_idx_t;

  localparam logic [15:0] BYTE_FULL  = 16'd255;
  localparam logic [15:0] SHORT_FULL = 16'd65535;

  // 24-bit significands of the single constants 1/255 and 1/65535
  localparam logic [23:0] RECIP_BYTE_MAN  = 24'h808081;
  localparam logic [23:0] RECIP_SHORT_MAN = 24'h800080;

  // Biased exponent offsets: leading-one position plus these gives the exponent
  localparam logic [7:0] EXP_OFS_BYTE  = 8'd96;
  localparam logic [7:0] EXP_OFS_SHORT = 8'd88;

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_UNITY    = 8'd150;

endpackage

### rtl/pixel_bit_depth_converter.sv
// Pixel bit depth converter top level.
// Depends on pbdc_pkg for depth codes, register indexes and scale constants.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel component per item:
//   in_sample_in (byte or short in the low bits, or IEEE single bits) and
//   in_source_present (0 forces a zero result).
//   Result channel (out_valid/out_ready) returns one out_sample_out per item.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   source_depth (index 0) and target_depth (index 1): 0 byte, 1 short,
//   2 or 3 single float. Other indexes are ignored. Write only while idle.
//   An accepted input item passes through the input register, then the
//   result register, before out_valid rises. Throughput: one item per cycle;
//   both stages advance every cycle unless the result register is stalled.
//   Reset (rst_n low, synchronous) empties both stages and sets both depths
//   to byte. When the receiver stalls, the result register holds and the
//   input stage fills; in_ready drops only when both stages are full.
module pixel_bit_depth_converter
  import pbdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_sample_in,
  input  logic        in_source_present,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  depth_t      src_depth_r, tgt_depth_r;
  logic        s1_valid_r;
  logic [31:0] s1_sample_r;
  logic        s1_present_r;
  logic        out_valid_r;
  logic [31:0] out_sample_r;
  logic        advance;
  logic [31:0] result_nxt;

  assign cfg_ready = 1'b1;

  // Advance the pipeline whenever the result register is free or being taken.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_depth_r <= DEPTH_BYTE;
      tgt_depth_r <= DEPTH_BYTE;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SOURCE_DEPTH: src_depth_r <= depth_t'(cfg_data);
        REG_TARGET_DEPTH: tgt_depth_r <= depth_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Input stage: hold while full and the result stage is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample_r  <= in_sample_in;
      s1_present_r <= in_source_present;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_sample_r <= result_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Conversion datapath. One 24x16 multiplier serves both directions:
  // integer to float multiplies the value by the single constant 1/src_max,
  // float to integer multiplies the significand by dst_max. Both products
  // then round to 24 significant bits, nearest even.
  logic        src_flt, tgt_flt, src_byte, tgt_byte;
  logic [15:0] ival, lim;
  logic        f_sign;
  logic [7:0]  f_exp, e_eff, rsh;
  logic [22:0] f_frac;
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic [39:0] prod, rem, half, rmask;
  logic [5:0]  lead;
  logic [4:0]  shamt;
  logic [23:0] mant;
  logic        up, carry;
  logic [24:0] mant_r;
  logic [40:0] qround, shifted;
  logic [7:0]  exp_out;
  logic [22:0] frac_out;
  logic [7:0]  q0;
  logic [15:0] q0x257;
  logic [7:0]  div257;

  always_comb begin
    src_flt  = (src_depth_r == DEPTH_FLOAT) || (src_depth_r == DEPTH_ALT);
    tgt_flt  = (tgt_depth_r == DEPTH_FLOAT) || (tgt_depth_r == DEPTH_ALT);
    src_byte = (src_depth_r == DEPTH_BYTE);
    tgt_byte = (tgt_depth_r == DEPTH_BYTE);
    ival     = src_byte ? {8'd0, s1_sample_r[7:0]} : s1_sample_r[15:0];
    lim      = tgt_byte ? BYTE_FULL : SHORT_FULL;
    f_sign   = s1_sample_r[31];
    f_exp    = s1_sample_r[30:23];
    f_frac   = s1_sample_r[22:0];

    mul_a = src_flt ? {(f_exp != 8'd0), f_frac}
                    : (src_byte ? RECIP_BYTE_MAN : RECIP_SHORT_MAN);
    mul_b = src_flt ? lim : ival;
    prod  = 40'(mul_a) * 40'(mul_b);

    lead = 6'd0;
    for (int i = 0; i < 40; i++) begin
      if (prod[i]) lead = 6'(i);
    end

    shamt  = (lead > 6'd23) ? 5'(lead - 6'd23) : 5'd0;
    mant   = 24'(prod >> shamt);
    rmask  = (40'd1 << shamt) - 40'd1;
    rem    = prod & rmask;
    half   = (shamt != 5'd0) ? (40'd1 << (shamt - 5'd1)) : 40'd0;
    up     = (shamt != 5'd0) && ((rem > half) || ((rem == half) && mant[0]));
    mant_r = {1'b0, mant} + 25'(up);
    carry  = mant_r[24];
    qround = 41'(mant_r) << shamt;

    // Integer to float
    exp_out  = 8'(lead) + 8'(carry) + (src_byte ? EXP_OFS_BYTE : EXP_OFS_SHORT);
    frac_out = carry ? 23'd0 : mant_r[22:0];

    // Float to integer: value = qround * 2^(e_eff - 150)
    e_eff   = (f_exp == 8'd0) ? 8'd1 : f_exp;
    rsh     = EXP_UNITY - e_eff;
    shifted = (rsh >= 8'd41) ? 41'd0 : (qround >> rsh);

    // Short to byte: divide by 257 with one correction step
    q0     = ival[15:8];
    q0x257 = {q0, q0};
    div257 = (ival < q0x257) ? (q0 - 8'd1) : q0;

    result_nxt = 32'd0;
    if (!s1_present_r) begin
      result_nxt = 32'd0;
    end else if (src_flt) begin
      if (tgt_flt) begin
        result_nxt = s1_sample_r;
      end else if (f_exp == EXP_ALL_ONES) begin
        result_nxt = ((f_frac != 23'd0) || f_sign) ? 32'd0 : {16'd0, lim};
      end else if (f_sign) begin
        result_nxt = 32'd0;
      end else if (f_exp >= EXP_UNITY) begin
        result_nxt = {16'd0, lim};
      end else if (shifted > 41'(lim)) begin
        result_nxt = {16'd0, lim};
      end else begin
        result_nxt = {16'd0, shifted[15:0]};
      end
    end else if (tgt_flt) begin
      result_nxt = (ival == 16'd0) ? 32'd0 : {1'b0, exp_out, frac_out};
    end else if (src_byte && !tgt_byte) begin
      result_nxt = {16'd0, ival[7:0], ival[7:0]};
    end else if (!src_byte && tgt_byte) begin
      result_nxt = {24'd0, div257};
    end else begin
      result_nxt = {16'd0, ival};
    end
  end

endmodule

### bench/pixel_bit_depth_converter_tb.sv
// Self-checking bench for pixel_bit_depth_converter: directed table, then random
// phases over every source/target depth pair. Depends on pbdc_pkg and the RTL.
`timescale 1ns / 1ps

module pixel_bit_depth_converter_tb;
  import pbdc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_sample_in = '0;
  logic        in_source_present = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_sample_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  reg_idx_t    cfg_index = REG_SOURCE_DEPTH;
  logic [1:0]  cfg_data = 2'd0;

  pixel_bit_depth_converter uut (.*);

  always #10 clk = ~clk;

  typedef struct {
    depth_t      src;
    depth_t      dst;
    logic [31:0] smp;
    logic        pres;
    logic        lit_ok;
    logic [31:0] lit;
  } conv_row_t;

  // Mirrors of the depth registers, following accepted writes
  depth_t      src_depth = DEPTH_BYTE;
  depth_t      dst_depth = DEPTH_BYTE;
  logic [31:0] pending_samples[$];
  int          fail_count = 0;
  bit          calm = 1'b0;
  // Literal expectation travelling with the current item, held with its payload
  logic        row_lit_ok = 1'b0;
  logic [31:0] row_lit = '0;
  int          stall_left = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int lead_one(input logic [63:0] p);
    for (int i = 63; i >= 0; i--) if (p[i]) return i;
    return -1;
  endfunction

  // Round a product to 24 significant bits, nearest even, keeping its scale
  function automatic logic [63:0] round_to_single(input logic [63:0] p);
    int          k;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    k = lead_one(p);
    if (k <= 23) return p;
    sh = k - 23;
    keep = p >> sh;
    rem = p & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep++;
    return keep << sh;
  endfunction

  function automatic logic [31:0] depth_convert(input logic [31:0] s, input logic pres,
                                                input depth_t src, input depth_t dst);
    logic [63:0] full;
    logic [63:0] prod;
    logic [63:0] v;
    logic [7:0]  e;
    logic [7:0]  ofs;
    int          ee;
    int          k;
    if (!pres) return '0;
    if (src == DEPTH_ALT) src = DEPTH_FLOAT;
    if (dst == DEPTH_ALT) dst = DEPTH_FLOAT;
    full = (dst == DEPTH_BYTE) ? 64'(BYTE_FULL) : 64'(SHORT_FULL);
    if (src == DEPTH_FLOAT) begin
      if (dst == DEPTH_FLOAT) return s;
      e = s[30:23];
      if (e == EXP_ALL_ONES) return (s[22:0] != 0 || s[31]) ? '0 : full[31:0];
      if (s[31] || s[30:0] == 0) return '0;
      v = (e != 0) ? {40'd0, 1'b1, s[22:0]} : {41'd0, s[22:0]};
      ee = (e != 0) ? e : 1;
      prod = round_to_single(v * full);
      if (ee >= EXP_UNITY) return full[31:0];
      if (EXP_UNITY - ee >= 64) return '0;
      v = prod >> (EXP_UNITY - ee);
      return (v > full) ? full[31:0] : v[31:0];
    end
    v = (src == DEPTH_BYTE) ? {56'd0, s[7:0]} : {48'd0, s[15:0]};
    if (dst == DEPTH_FLOAT) begin
      if (v == 0) return '0;
      prod = round_to_single(v * ((src == DEPTH_BYTE) ? RECIP_BYTE_MAN : RECIP_SHORT_MAN));
      k = lead_one(prod);
      ofs = (src == DEPTH_BYTE) ? EXP_OFS_BYTE : EXP_OFS_SHORT;
      prod = prod >> (k - 23);
      return {1'b0, 8'(k + ofs), prod[22:0]};
    end
    v = (v * full) / ((src == DEPTH_BYTE) ? 64'(BYTE_FULL) : 64'(SHORT_FULL));
    return v[31:0];
  endfunction

  // Monitor: track register writes, predict each accepted item, check results
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SOURCE_DEPTH) src_depth <= depth_t'(cfg_data);
        else if (cfg_index == REG_TARGET_DEPTH) dst_depth <= depth_t'(cfg_data);
      end
      if (in_valid && in_ready) begin
        // Table rows with a typed-in value are checked against that value
        want = row_lit_ok ? row_lit
               : depth_convert(in_sample_in, in_source_present, src_depth, dst_depth);
        pending_samples.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_samples.size() == 0) report_mismatch("unexpected result", out_sample_out, 'x);
        else begin
          want = pending_samples.pop_front();
          if (out_sample_out !== want) report_mismatch("sample_out", out_sample_out, want);
        end
      end
    end
  end

  // Receiver: stall in random bursts, never once the run winds down
  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(7) == 0) begin
      stall_left <= $urandom_range(8);
      out_ready <= 1'b0;
    end else out_ready <= 1'b1;
  end

  // Hold until every expected result has come, then let the pipe settle
  task automatic wait_drained();
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_depths(input depth_t src, input depth_t dst);
    if (src == src_depth && dst == dst_depth) return;
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    write_reg(REG_SOURCE_DEPTH, src);
    write_reg(REG_TARGET_DEPTH, dst);
    @(posedge clk);
  endtask

  // Drive one item and hold it until accepted; maybe idle afterward
  task automatic send_item(input logic [31:0] smp, input logic pres,
                           input logic lit_ok, input logic [31:0] lit);
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_source_present <= pres;
    row_lit_ok <= lit_ok;
    row_lit <= lit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!calm && $urandom_range(5) == 0) begin
      in_valid <= 1'b0;
      row_lit_ok <= 1'b0;
      repeat ($urandom_range(9, 1)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_sample(input depth_t src);
    logic [31:0] r;
    r = $urandom;
    if (src < DEPTH_FLOAT) return r;
    case ($urandom_range(9))
      0: return {r[31], 8'hFF, r[22:0]};                       // inf and NaN
      1: return {r[31], 8'h00, r[22:0]};                       // zero and subnormal
      2: return r;
      3: return {1'b1, r[30:0]};
      4: return $shortrealtobits(shortreal'($urandom_range(255)) / 255.0);
      5: return $shortrealtobits(shortreal'($urandom_range(65535)) / 65535.0);
      6: return {1'b0, 8'd127, 23'd0} - r[3:0];                 // 1.0 and just below it
      default: return {1'b0, 8'($urandom_range(126, 100)), r[22:0]};
    endcase
  endfunction

  conv_row_t directed[] = '{
    '{DEPTH_BYTE,  DEPTH_BYTE,  32'h0000_00FF, 1, 1, 32'h0000_00FF},
    '{DEPTH_BYTE,  DEPTH_BYTE,  32'h0000_0000, 1, 1, 32'h0000_0000},
    '{DEPTH_BYTE,  DEPTH_BYTE,  32'hFFFF_FF00, 1, 1, 32'h0000_0000},
    '{DEPTH_BYTE,  DEPTH_BYTE,  32'hFFFF_FFFF, 0, 1, 32'h0000_0000},
    '{DEPTH_BYTE,  DEPTH_SHORT, 32'h0000_00FF, 1, 1, 32'h0000_FFFF},
    '{DEPTH_BYTE,  DEPTH_SHORT, 32'h1234_5680, 1, 0, 32'h0},
    '{DEPTH_BYTE,  DEPTH_FLOAT, 32'h0000_00FF, 1, 1, 32'h3F80_0000},
    '{DEPTH_BYTE,  DEPTH_FLOAT, 32'h0000_0001, 1, 0, 32'h0},
    '{DEPTH_BYTE,  DEPTH_FLOAT, 32'hAAAA_AA80, 0, 1, 32'h0000_0000},
    '{DEPTH_SHORT, DEPTH_BYTE,  32'hFFFF_FFFF, 1, 1, 32'h0000_00FF},
    '{DEPTH_SHORT, DEPTH_BYTE,  32'h0000_0100, 1, 0, 32'h0},
    '{DEPTH_SHORT, DEPTH_ALT,   32'h0000_FFFF, 1, 1, 32'h3F80_0000},
    '{DEPTH_SHORT, DEPTH_FLOAT, 32'h0000_0001, 1, 0, 32'h0},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'h7FC0_0001, 1, 1, 32'h0000_0000},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'h7F80_0000, 1, 1, 32'h0000_00FF},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'hFF80_0000, 1, 1, 32'h0000_0000},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'h8000_0000, 1, 1, 32'h0000_0000},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'h3F80_0000, 1, 1, 32'h0000_00FF},
    '{DEPTH_FLOAT, DEPTH_BYTE,  32'h3F7F_FFFF, 1, 0, 32'h0},
    '{DEPTH_FLOAT, DEPTH_SHORT, 32'h3F80_0000, 1, 1, 32'h0000_FFFF},
    '{DEPTH_FLOAT, DEPTH_SHORT, 32'h4B00_0000, 1, 1, 32'h0000_FFFF},
    '{DEPTH_FLOAT, DEPTH_SHORT, 32'h3F00_0000, 1, 0, 32'h0},
    '{DEPTH_ALT,   DEPTH_FLOAT, 32'hFFC1_2345, 1, 1, 32'hFFC1_2345},
    '{DEPTH_FLOAT, DEPTH_ALT,   32'h8000_0001, 0, 1, 32'h0000_0000}
  };

  initial begin
    depth_t ps;
    depth_t pt;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Spare indexes must leave both depths alone
    write_reg(REG_SPARE_A, 2'd2);
    write_reg(REG_SPARE_B, 2'd1);
    foreach (directed[i]) begin
      set_depths(directed[i].src, directed[i].dst);
      send_item(directed[i].smp, directed[i].pres, directed[i].lit_ok, directed[i].lit);
    end
    // Random phases over all sixteen depth pairs, code three included
    for (int p = 0; p < 16; p++) begin
      ps = depth_t'(p / 4);
      pt = depth_t'(p % 4);
      set_depths(ps, pt);
      if (p == 15) calm = 1'b1;
      for (int n = 0; n < 116; n++) send_item(pick_sample(ps), $urandom_range(9) != 0, 0, '0);
    end
    in_valid <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);
    if (fail_count == 0) $display("pixel_bit_depth_converter test passed");
    else $display("pixel_bit_depth_converter test failed");
    $finish;
  end

  // Timeout well beyond the slowest legal run
  initial begin
    #20ms;
    $display("pixel_bit_depth_converter test failed");
    $finish;
  end

endmodule

### pixel_bit_depth_converter.f
rtl/pbdc_pkg.sv
rtl/pixel_bit_depth_converter.sv
bench/pixel_bit_depth_converter_tb.sv
